// ----- hdl/pkpad_pkg.sv -----
// Shared types, codes and constants of the PKCS#1 v1.5 signature padder.
// Holds the DigestInfo prefix table; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package pkpad_pkg;

  localparam int unsigned MAX_BLOCK_BYTES  = 512;
  localparam int unsigned PREFIX_MAX_BYTES = 19;
  localparam int unsigned PREFIX_ROW       = 19;
  localparam int unsigned PREFIX_KINDS     = 10;
  localparam int unsigned MIN_OVERHEAD     = 11;

  localparam int unsigned OUT_LEN_W  = 10;
  localparam int unsigned PAY_LEN_W  = 9;
  localparam int unsigned DKIND_W    = 4;
  localparam int unsigned PIDX_W     = 5;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SUM_W      = 12;

  localparam logic [7:0] PAD_BYTE  = 8'hFF;
  localparam logic [7:0] BT_BYTE   = 8'h01;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_UNUSED  = 2'd3
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SMALL   = 2'd1,
    ST_DROPPED = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUT_LENGTH     = 2'd0,
    REG_PAYLOAD_LENGTH = 2'd1,
    REG_DIGEST_KIND    = 2'd2,
    REG_NONE           = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] out_length;
    logic [PAY_LEN_W-1:0] payload_length;
    logic [DKIND_W-1:0]   digest_kind;
  } cfg_t;

  function automatic logic [PIDX_W-1:0] prefix_len(input logic [DKIND_W-1:0] dk);
    logic [PIDX_W-1:0] len;
    case (dk)
      4'd1:                                     len = PIDX_W'(15);
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: len = PIDX_W'(19);
      default:                                  len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [DKIND_W-1:0] dk,
                                             input logic [PIDX_W-1:0]  idx);
    logic [7:0] b;
    logic [7:0] sz;
    logic [7:0] alg;
    b = ZERO_BYTE;
    sz = ZERO_BYTE;
    alg = ZERO_BYTE;
    case (dk)
      4'd2:    begin sz = 8'h2d; alg = 8'h04; end
      4'd3:    begin sz = 8'h31; alg = 8'h01; end
      4'd4:    begin sz = 8'h41; alg = 8'h02; end
      4'd5:    begin sz = 8'h51; alg = 8'h03; end
      4'd6:    begin sz = 8'h2d; alg = 8'h07; end
      4'd7:    begin sz = 8'h31; alg = 8'h08; end
      4'd8:    begin sz = 8'h41; alg = 8'h09; end
      4'd9:    begin sz = 8'h51; alg = 8'h0a; end
      default: begin sz = ZERO_BYTE; alg = ZERO_BYTE; end
    endcase
    if (dk == 4'd1) begin
      case (idx)
        5'd0:    b = 8'h30;
        5'd1:    b = 8'h21;
        5'd2:    b = 8'h30;
        5'd3:    b = 8'h09;
        5'd4:    b = 8'h06;
        5'd5:    b = 8'h05;
        5'd6:    b = 8'h2b;
        5'd7:    b = 8'h0e;
        5'd8:    b = 8'h03;
        5'd9:    b = 8'h02;
        5'd10:   b = 8'h1a;
        5'd11:   b = 8'h05;
        5'd12:   b = 8'h00;
        5'd13:   b = 8'h04;
        5'd14:   b = 8'h14;
        default: b = ZERO_BYTE;
      endcase
    end else if (sz != ZERO_BYTE) begin
      case (idx)
        5'd0:    b = 8'h30;
        5'd1:    b = sz;
        5'd2:    b = 8'h30;
        5'd3:    b = 8'h0d;
        5'd4:    b = 8'h06;
        5'd5:    b = 8'h09;
        5'd6:    b = 8'h60;
        5'd7:    b = 8'h86;
        5'd8:    b = 8'h48;
        5'd9:    b = 8'h01;
        5'd10:   b = 8'h65;
        5'd11:   b = 8'h03;
        5'd12:   b = 8'h04;
        5'd13:   b = 8'h02;
        5'd14:   b = alg;
        5'd15:   b = 8'h05;
        5'd16:   b = 8'h00;
        5'd17:   b = 8'h04;
        5'd18:   b = (sz == 8'h2d) ? 8'h1c : (sz == 8'h31) ? 8'h20 :
                     (sz == 8'h41) ? 8'h30 : 8'h40;
        default: b = ZERO_BYTE;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pkpad_cfg.sv -----
// Configuration register file of the signature padder.
// Depends on pkpad_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none
module pkpad_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [pkpad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pkpad_pkg::CFG_DATA_W-1:0]  cfg_data,
  output pkpad_pkg::cfg_t                        cfg
);

  pkpad_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.out_length     <= pkpad_pkg::OUT_LEN_W'(256);
      regs.payload_length <= pkpad_pkg::PAY_LEN_W'(32);
      regs.digest_kind    <= pkpad_pkg::DKIND_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        pkpad_pkg::REG_OUT_LENGTH:
          regs.out_length <= cfg_data[pkpad_pkg::OUT_LEN_W-1:0];
        pkpad_pkg::REG_PAYLOAD_LENGTH:
          regs.payload_length <= cfg_data[pkpad_pkg::PAY_LEN_W-1:0];
        pkpad_pkg::REG_DIGEST_KIND:
          regs.digest_kind <= cfg_data[pkpad_pkg::DKIND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule
`default_nettype wire

// ----- hdl/pkpad_hdr.sv -----
// Header byte generator: 00 01 FF..FF 00 followed by the DigestInfo prefix.
// Depends on pkpad_pkg for the prefix table and widths.
`timescale 1ns / 1ps
`default_nettype none
module pkpad_hdr (
  input  wire logic [pkpad_pkg::OUT_LEN_W-1:0] position,
  input  wire logic [pkpad_pkg::SUM_W-1:0]     hlen,
  input  wire logic [pkpad_pkg::PIDX_W-1:0]    plen,
  input  wire logic [pkpad_pkg::DKIND_W-1:0]   digest_kind,
  output logic      [7:0]                      hdr_byte
);

  logic [pkpad_pkg::SUM_W-1:0] pos_plen;
  logic [pkpad_pkg::SUM_W-1:0] idx_full;

  assign pos_plen = pkpad_pkg::SUM_W'(position) + pkpad_pkg::SUM_W'(plen);
  assign idx_full = pos_plen - hlen;

  always_comb begin
    if (position == '0) begin
      hdr_byte = pkpad_pkg::ZERO_BYTE;
    end else if (position == pkpad_pkg::OUT_LEN_W'(1)) begin
      hdr_byte = pkpad_pkg::BT_BYTE;
    end else if (pos_plen + pkpad_pkg::SUM_W'(1) < hlen) begin
      hdr_byte = pkpad_pkg::PAD_BYTE;
    end else if (pos_plen + pkpad_pkg::SUM_W'(1) == hlen) begin
      hdr_byte = pkpad_pkg::ZERO_BYTE;
    end else if (idx_full >= pkpad_pkg::SUM_W'(pkpad_pkg::PREFIX_ROW)) begin
      hdr_byte = pkpad_pkg::ZERO_BYTE;
    end else begin
      hdr_byte = pkpad_pkg::prefix_byte(digest_kind, idx_full[pkpad_pkg::PIDX_W-1:0]);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pkcs1_v15_signature_padder_unit.sv -----
// Top level of the PKCS#1 v1.5 signature padder: input register, step logic,
// result register. Depends on pkpad_pkg, pkpad_cfg and pkpad_hdr.
// An item taken into the input reg has its result, if any, registered in the result reg.
// Throughput: 1 item per cycle while the result is not stalled; the step logic and block
// position update sit between the input register and the result register.
// Reset: synchronous rst empties both registers and leaves the block idle
// at position 0 with registers at 256 / 32 / 3.
`timescale 1ns / 1ps
`default_nettype none
module pkcs1_v15_signature_padder_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire pkpad_pkg::in_item_t               item,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output pkpad_pkg::out_item_t                   result,
  input  wire logic                              cfg_we,
  input  wire logic [pkpad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pkpad_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pkpad_pkg::cfg_t      cfg;
  pkpad_pkg::in_item_t  held;
  pkpad_pkg::out_item_t res_next;
  logic                 held_valid;
  logic                 advance;
  logic                 emit;
  logic                 active;
  logic                 active_next;
  logic [pkpad_pkg::OUT_LEN_W-1:0] position;
  logic [pkpad_pkg::OUT_LEN_W-1:0] position_next;
  logic [pkpad_pkg::PIDX_W-1:0]    plen;
  logic [pkpad_pkg::SUM_W-1:0]     hlen;
  logic [pkpad_pkg::SUM_W-1:0]     olen;
  logic [pkpad_pkg::SUM_W-1:0]     pos_inc;
  logic [pkpad_pkg::SUM_W-1:0]     need;
  logic [7:0]                      hdr_byte;
  logic                            too_small;

  pkpad_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign plen = pkpad_pkg::prefix_len(cfg.digest_kind);
  assign olen = pkpad_pkg::SUM_W'(cfg.out_length);
  assign hlen = (pkpad_pkg::SUM_W'(cfg.payload_length) > olen) ? '0 :
                olen - pkpad_pkg::SUM_W'(cfg.payload_length);
  assign pos_inc = pkpad_pkg::SUM_W'(position) + pkpad_pkg::SUM_W'(1);
  assign need = pkpad_pkg::SUM_W'(cfg.payload_length) + pkpad_pkg::SUM_W'(plen) +
                pkpad_pkg::SUM_W'(pkpad_pkg::MIN_OVERHEAD);
  assign too_small = (olen < need) ||
                     (olen > pkpad_pkg::SUM_W'(pkpad_pkg::MAX_BLOCK_BYTES)) ||
                     (pkpad_pkg::SUM_W'(plen) > pkpad_pkg::SUM_W'(pkpad_pkg::PREFIX_MAX_BYTES));

  pkpad_hdr u_hdr (
    .position    (position),
    .hlen        (hlen),
    .plen        (plen),
    .digest_kind (cfg.digest_kind),
    .hdr_byte    (hdr_byte)
  );

  assign advance    = !result_valid || !result_stall;
  assign item_stall = held_valid && !advance;

  always_comb begin
    emit          = 1'b0;
    res_next      = '0;
    active_next   = active;
    position_next = position;
    case (held.kind)
      pkpad_pkg::KIND_START: begin
        position_next = '0;
        if (too_small) begin
          active_next     = 1'b0;
          emit            = 1'b1;
          res_next.status = pkpad_pkg::ST_SMALL;
          res_next.last   = 1'b1;
        end else begin
          active_next = 1'b1;
        end
      end
      pkpad_pkg::KIND_TICK: begin
        if (active && (pkpad_pkg::SUM_W'(position) < hlen)) begin
          emit              = 1'b1;
          res_next.out_byte = hdr_byte;
          res_next.last     = (pos_inc == olen);
          if (pos_inc >= olen) begin
            active_next   = 1'b0;
            position_next = '0;
          end else begin
            position_next = pos_inc[pkpad_pkg::OUT_LEN_W-1:0];
          end
        end
      end
      pkpad_pkg::KIND_PAYLOAD: begin
        emit = 1'b1;
        if (!active || (pkpad_pkg::SUM_W'(position) < hlen) ||
            (pkpad_pkg::SUM_W'(position) >= olen)) begin
          res_next.status = pkpad_pkg::ST_DROPPED;
        end else begin
          res_next.out_byte = held.data_byte;
          res_next.last     = (pos_inc == olen);
          if (pos_inc >= olen) begin
            active_next   = 1'b0;
            position_next = '0;
          end else begin
            position_next = pos_inc[pkpad_pkg::OUT_LEN_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!held_valid || advance) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!held_valid || advance) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      active       <= 1'b0;
      position     <= '0;
    end else if (advance) begin
      result_valid <= held_valid && emit;
      if (held_valid) begin
        active   <= active_next;
        position <= position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid && emit) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pkpad_chk.sv -----
// Port-level checker for the signature padder top level, with its bind.
// Depends on pkpad_pkg for status codes and the item structs.
`timescale 1ns / 1ps
`default_nettype none
module pkpad_chk (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 result_valid,
  input wire logic                 result_stall,
  input wire pkpad_pkg::out_item_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_small: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == pkpad_pkg::ST_SMALL |->
      result.last && result.out_byte == pkpad_pkg::ZERO_BYTE)
    else $error("too-small result not a zero last byte");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == pkpad_pkg::ST_DROPPED |->
      !result.last && result.out_byte == pkpad_pkg::ZERO_BYTE)
    else $error("dropped-byte result malformed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status != pkpad_pkg::ST_RSVD)
    else $error("reserved status code");

endmodule

bind pkcs1_v15_signature_padder_unit pkpad_chk u_pkpad_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
`default_nettype wire
